// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define ASSERT_AT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(label, clk, rstn, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`endif

// ===== rtl/ldq_pkg.sv =====
package ldq_pkg;

  // Command codes.
  localparam logic [3:0] OP_PUSH_F    = 4'd0;
  localparam logic [3:0] OP_PUSH_B    = 4'd1;
  localparam logic [3:0] OP_POP_F     = 4'd2;
  localparam logic [3:0] OP_POP_B     = 4'd3;
  localparam logic [3:0] OP_INSERT    = 4'd4;
  localparam logic [3:0] OP_REM_AT    = 4'd5;
  localparam logic [3:0] OP_REM_FIRST = 4'd6;
  localparam logic [3:0] OP_REM_ALL   = 4'd7;
  localparam logic [3:0] OP_FIND      = 4'd8;
  localparam logic [3:0] OP_PEEK_F    = 4'd9;
  localparam logic [3:0] OP_PEEK_B    = 4'd10;
  localparam logic [3:0] OP_CLEAR     = 4'd11;

  // Status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_MISS  = 2'd3;

  typedef struct packed {
    logic [3:0]  op;
    logic [31:0] item_value;
    logic [5:0]  slot_handle;
    logic        handle_given;
  } in_t;

  typedef struct packed {
    logic [31:0] result_value;
    logic [5:0]  result_handle;
    logic [1:0]  status;
    logic [6:0]  element_count;
  } out_t;

endpackage

// ===== rtl/linked_deque_with_search.sv =====
// Bounded double-ended list with search, held as linked slots in a slot memory.
// The input channel (in_valid, in_ready, in_data) carries one command per
// transaction; the output channel (out_valid, out_ready, out_data) returns one
// result transaction per command, in order.
// Commands are processed one at a time. in_ready is high only while the
// sequencer is idle, and it stays low until the result is placed in the output
// register, so a stalled receiver holds off the next command only once a second
// result is ready. Find, remove_first and remove_all walk the list through the
// slot memory at one element per cycle, pausing to unlink each element that
// they remove. The single read port of the slot memory, with its registered
// read, sets this pace. After reset the block sweeps both memories, marking
// every slot free and restoring the free stack; in_ready stays low meanwhile.
// The clear command runs the same sweep and then reports its result.
module linked_deque_with_search
  import ldq_pkg::*;
#(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = AW + 1;
  localparam int DW = DATA_WIDTH;
  // Slot word: {in_use, prev, next, data}.
  localparam int WW = 1 + 2 * AW + DW;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_DEC, S_TAKE, S_INS_CHK, S_RMAT_CHK, S_END_RD,
    S_WALK, S_DROP, S_PW0, S_PW1, S_WNEXT, S_DONE
  } state_t;

  // Slot memory and free stack, both with a registered read.
  logic [WW-1:0] slot_mem [DEPTH];
  logic [AW-1:0] fs_mem [DEPTH];
  logic [WW-1:0] slot_q;
  logic [AW-1:0] fs_q;

  logic          slot_we;
  logic [AW-1:0] slot_waddr;
  logic [WW-1:0] slot_wdata;
  logic [AW-1:0] slot_raddr;
  logic          fs_we;
  logic [AW-1:0] fs_waddr;
  logic [AW-1:0] fs_wdata;
  logic [AW-1:0] fs_raddr;

  state_t        state_r, state_nxt;
  logic [AW-1:0] init_r, init_nxt;
  logic          clr_rep_r, clr_rep_nxt;
  logic [3:0]    op_r, op_nxt;
  logic [DW-1:0] val_r, val_nxt;
  logic [5:0]    h_r, h_nxt;
  logic          given_r, given_nxt;
  logic [AW-1:0] first_r, first_nxt;
  logic [AW-1:0] last_r, last_nxt;
  logic [CW-1:0] used_r, used_nxt;
  logic [CW-1:0] ftop_r, ftop_nxt;
  logic [AW-1:0] s_r, s_nxt;
  logic [WW-1:0] w_r, w_nxt;
  logic [AW-1:0] cur_r, cur_nxt;
  logic [CW-1:0] vis_r, vis_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [CW-1:0] rem_r, rem_nxt;
  logic [AW-1:0] pa0_r, pa0_nxt, pa1_r, pa1_nxt;
  logic [AW-1:0] pv0_r, pv0_nxt, pv1_r, pv1_nxt;
  logic          pen1_r, pen1_nxt;
  logic [31:0]   res_value_r, res_value_nxt;
  logic [5:0]    res_handle_r, res_handle_nxt;
  logic [1:0]    res_status_r, res_status_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_t          out_data_r, out_data_nxt;

  // Fields of the word just read and of the saved word.
  logic          q_use;
  logic [AW-1:0] q_next;
  logic [DW-1:0] q_data;
  logic [AW-1:0] w_prev, w_next;
  logic          full, h_in_range, q_match, at_first, at_last;
  logic [AW-1:0] h_addr, ins_b;
  state_t        ret_state;

  assign q_use      = slot_q[WW-1];
  assign q_next     = slot_q[DW+AW-1 -: AW];
  assign q_data     = slot_q[DW-1:0];
  assign w_prev     = w_r[WW-2 -: AW];
  assign w_next     = w_r[DW+AW-1 -: AW];
  assign full       = (used_r == CW'(DEPTH));
  assign h_in_range = (32'(h_r) < 32'(DEPTH));
  assign h_addr     = AW'(h_r);
  assign q_match    = (q_data == val_r);
  assign at_first   = (s_r == first_r);
  assign at_last    = (s_r == last_r);
  assign ins_b      = (op_r == OP_INSERT && given_r) ? h_addr : first_r;
  // After an unlink, remove_all goes on walking; everything else reports.
  assign ret_state  = (op_r == OP_REM_ALL) ? S_WNEXT : S_DONE;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    slot_q <= slot_mem[slot_raddr];
  end

  always_ff @(posedge clk) begin
    if (fs_we) begin
      fs_mem[fs_waddr] <= fs_wdata;
    end
    fs_q <= fs_mem[fs_raddr];
  end

  always_comb begin
    state_nxt      = state_r;
    init_nxt       = init_r;
    clr_rep_nxt    = clr_rep_r;
    op_nxt         = op_r;
    val_nxt        = val_r;
    h_nxt          = h_r;
    given_nxt      = given_r;
    first_nxt      = first_r;
    last_nxt       = last_r;
    used_nxt       = used_r;
    ftop_nxt       = ftop_r;
    s_nxt          = s_r;
    w_nxt          = w_r;
    cur_nxt        = cur_r;
    vis_nxt        = vis_r;
    n_nxt          = n_r;
    rem_nxt        = rem_r;
    pa0_nxt        = pa0_r;
    pa1_nxt        = pa1_r;
    pv0_nxt        = pv0_r;
    pv1_nxt        = pv1_r;
    pen1_nxt       = pen1_r;
    res_value_nxt  = res_value_r;
    res_handle_nxt = res_handle_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_data_nxt   = out_data_r;
    slot_we        = 1'b0;
    slot_waddr     = s_r;
    slot_wdata     = '0;
    slot_raddr     = cur_r;
    fs_we          = 1'b0;
    fs_waddr       = init_r;
    fs_wdata       = init_r;
    fs_raddr       = AW'(ftop_r - CW'(1));

    case (state_r)
      S_INIT: begin
        // One slot a cycle: mark it free and put it back on the stack.
        slot_we    = 1'b1;
        slot_waddr = init_r;
        slot_wdata = '0;
        fs_we      = 1'b1;
        init_nxt   = init_r + AW'(1);
        if (init_r == AW'(DEPTH - 1)) begin
          first_nxt   = '0;
          last_nxt    = '0;
          used_nxt    = '0;
          ftop_nxt    = CW'(DEPTH);
          clr_rep_nxt = 1'b0;
          state_nxt   = clr_rep_r ? S_DONE : S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          op_nxt         = in_data.op;
          val_nxt        = DW'(in_data.item_value);
          h_nxt          = in_data.slot_handle;
          given_nxt      = in_data.handle_given;
          res_value_nxt  = '0;
          res_handle_nxt = '0;
          res_status_nxt = ST_OK;
          state_nxt      = S_DEC;
        end
      end

      S_DEC: begin
        case (op_r)
          OP_PUSH_F, OP_PUSH_B: begin
            if (full) begin
              res_status_nxt = ST_FULL;
              state_nxt      = S_DONE;
            end else begin
              state_nxt = S_TAKE;
            end
          end
          OP_INSERT: begin
            if (given_r) begin
              if (!h_in_range) begin
                res_status_nxt = ST_MISS;
                state_nxt      = S_DONE;
              end else begin
                slot_raddr = h_addr;
                state_nxt  = S_INS_CHK;
              end
            end else if (full) begin
              res_status_nxt = ST_FULL;
              state_nxt      = S_DONE;
            end else begin
              state_nxt = S_TAKE;
            end
          end
          OP_POP_F, OP_POP_B, OP_PEEK_F, OP_PEEK_B: begin
            if (used_r == '0) begin
              res_status_nxt = ST_EMPTY;
              state_nxt      = S_DONE;
            end else begin
              if (op_r == OP_POP_F || op_r == OP_PEEK_F) begin
                s_nxt      = first_r;
                slot_raddr = first_r;
              end else begin
                s_nxt      = last_r;
                slot_raddr = last_r;
              end
              state_nxt = S_END_RD;
            end
          end
          OP_REM_AT: begin
            if (!given_r || !h_in_range) begin
              res_status_nxt = ST_MISS;
              state_nxt      = S_DONE;
            end else begin
              slot_raddr = h_addr;
              state_nxt  = S_RMAT_CHK;
            end
          end
          OP_REM_FIRST, OP_REM_ALL, OP_FIND: begin
            vis_nxt = '0;
            n_nxt   = used_r;
            rem_nxt = '0;
            cur_nxt = first_r;
            if (used_r == '0) begin
              res_status_nxt = (op_r == OP_REM_ALL) ? ST_OK : ST_MISS;
              state_nxt      = S_DONE;
            end else begin
              slot_raddr = first_r;
              state_nxt  = S_WALK;
            end
          end
          OP_CLEAR: begin
            init_nxt    = '0;
            clr_rep_nxt = 1'b1;
            state_nxt   = S_INIT;
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end

      S_INS_CHK: begin
        if (!q_use) begin
          res_status_nxt = ST_MISS;
          state_nxt      = S_DONE;
        end else if (full) begin
          res_status_nxt = ST_FULL;
          state_nxt      = S_DONE;
        end else begin
          w_nxt     = slot_q;
          state_nxt = S_TAKE;
        end
      end

      S_TAKE: begin
        // fs_q holds the slot on top of the free stack.
        s_nxt          = fs_q;
        ftop_nxt       = ftop_r - CW'(1);
        used_nxt       = used_r + CW'(1);
        res_handle_nxt = 6'(fs_q);
        slot_we        = 1'b1;
        slot_waddr     = fs_q;
        pen1_nxt       = 1'b0;
        if (used_r == '0) begin
          first_nxt  = fs_q;
          last_nxt   = fs_q;
          slot_wdata = {1'b1, AW'(0), AW'(0), val_r};
          state_nxt  = S_DONE;
        end else if (op_r == OP_PUSH_B) begin
          slot_wdata = {1'b1, last_r, AW'(0), val_r};
          pa0_nxt    = last_r;
          pv0_nxt    = fs_q;
          last_nxt   = fs_q;
          slot_raddr = last_r;
          state_nxt  = S_PW0;
        end else if (ins_b == first_r) begin
          slot_wdata = {1'b1, AW'(0), ins_b, val_r};
          first_nxt  = fs_q;
          pen1_nxt   = 1'b1;
          pa1_nxt    = ins_b;
          pv1_nxt    = fs_q;
          slot_raddr = ins_b;
          state_nxt  = S_PW1;
        end else begin
          // Inserting in the middle: the saved word is the handle's slot.
          slot_wdata = {1'b1, w_prev, ins_b, val_r};
          pa0_nxt    = w_prev;
          pv0_nxt    = fs_q;
          pen1_nxt   = 1'b1;
          pa1_nxt    = ins_b;
          pv1_nxt    = fs_q;
          slot_raddr = w_prev;
          state_nxt  = S_PW0;
        end
      end

      S_END_RD: begin
        res_value_nxt  = 32'(q_data);
        res_handle_nxt = 6'(s_r);
        if (op_r == OP_PEEK_F || op_r == OP_PEEK_B) begin
          state_nxt = S_DONE;
        end else begin
          w_nxt     = slot_q;
          state_nxt = S_DROP;
        end
      end

      S_RMAT_CHK: begin
        if (!q_use) begin
          res_status_nxt = ST_MISS;
          state_nxt      = S_DONE;
        end else begin
          res_value_nxt  = 32'(q_data);
          res_handle_nxt = h_r;
          s_nxt          = h_addr;
          w_nxt          = slot_q;
          state_nxt      = S_DROP;
        end
      end

      S_WALK: begin
        vis_nxt = vis_r + CW'(1);
        if (q_match && op_r != OP_REM_ALL) begin
          res_handle_nxt = 6'(cur_r);
          if (op_r == OP_FIND) begin
            state_nxt = S_DONE;
          end else begin
            res_value_nxt = 32'(q_data);
            s_nxt         = cur_r;
            w_nxt         = slot_q;
            state_nxt     = S_DROP;
          end
        end else if (q_match) begin
          rem_nxt   = rem_r + CW'(1);
          s_nxt     = cur_r;
          w_nxt     = slot_q;
          cur_nxt   = q_next;
          state_nxt = S_DROP;
        end else if (vis_r + CW'(1) == n_r) begin
          if (op_r == OP_REM_ALL) begin
            res_value_nxt = 32'(rem_r);
          end else begin
            res_status_nxt = ST_MISS;
          end
          state_nxt = S_DONE;
        end else begin
          cur_nxt    = q_next;
          slot_raddr = q_next;
        end
      end

      S_DROP: begin
        // Unlink s_r, whose word is saved, and push it on the free stack.
        slot_we    = 1'b1;
        slot_waddr = s_r;
        slot_wdata = {1'b0, w_r[WW-2:0]};
        fs_we      = 1'b1;
        fs_waddr   = AW'(ftop_r);
        fs_wdata   = s_r;
        ftop_nxt   = ftop_r + CW'(1);
        used_nxt   = used_r - CW'(1);
        pa0_nxt    = w_prev;
        pv0_nxt    = w_next;
        pa1_nxt    = w_next;
        pv1_nxt    = w_prev;
        pen1_nxt   = !at_last;
        if (at_first) begin
          first_nxt = w_next;
        end
        if (at_last) begin
          last_nxt = w_prev;
        end
        if (used_r == CW'(1)) begin
          first_nxt = '0;
          last_nxt  = '0;
        end
        slot_raddr = at_first ? w_next : w_prev;
        if (!at_first) begin
          state_nxt = S_PW0;
        end else if (!at_last) begin
          state_nxt = S_PW1;
        end else begin
          state_nxt = ret_state;
        end
      end

      S_PW0: begin
        slot_we    = 1'b1;
        slot_waddr = pa0_r;
        slot_wdata = {slot_q[WW-1:DW+AW], pv0_r, slot_q[DW-1:0]};
        slot_raddr = pa1_r;
        state_nxt  = pen1_r ? S_PW1 : ret_state;
      end

      S_PW1: begin
        slot_we    = 1'b1;
        slot_waddr = pa1_r;
        slot_wdata = {slot_q[WW-1], pv1_r, slot_q[DW+AW-1:0]};
        state_nxt  = ret_state;
      end

      S_WNEXT: begin
        if (vis_r == n_r) begin
          res_value_nxt = 32'(rem_r);
          state_nxt     = S_DONE;
        end else begin
          slot_raddr = cur_r;
          state_nxt  = S_WALK;
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{result_value:  res_value_r,
                            result_handle: res_handle_r,
                            status:        res_status_r,
                            element_count: 7'(used_r)};
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      init_r      <= '0;
      clr_rep_r   <= 1'b0;
      first_r     <= '0;
      last_r      <= '0;
      used_r      <= '0;
      ftop_r      <= CW'(DEPTH);
      pen1_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      init_r      <= init_nxt;
      clr_rep_r   <= clr_rep_nxt;
      first_r     <= first_nxt;
      last_r      <= last_nxt;
      used_r      <= used_nxt;
      ftop_r      <= ftop_nxt;
      pen1_r      <= pen1_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r         <= op_nxt;
    val_r        <= val_nxt;
    h_r          <= h_nxt;
    given_r      <= given_nxt;
    s_r          <= s_nxt;
    w_r          <= w_nxt;
    cur_r        <= cur_nxt;
    vis_r        <= vis_nxt;
    n_r          <= n_nxt;
    rem_r        <= rem_nxt;
    pa0_r        <= pa0_nxt;
    pa1_r        <= pa1_nxt;
    pv0_r        <= pv0_nxt;
    pv1_r        <= pv1_nxt;
    res_value_r  <= res_value_nxt;
    res_handle_r <= res_handle_nxt;
    res_status_r <= res_status_nxt;
    out_data_r   <= out_data_nxt;
  end

endmodule

// ===== rtl/ldq_chk.sv =====
`include "assert_macros.svh"

module ldq_chk
  import ldq_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  // A waiting result transaction holds until it is taken.
  `ASSERT_AT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_data), "result changed while stalled")

  // Commands are handled one at a time.
  `ASSERT_AT(a_one_at_a_time, clk, rst_n, in_valid && in_ready |=> !in_ready, "second command taken while busy")

  // A refused push or insert only happens on a full store.
  `ASSERT_AT(a_full_count, clk, rst_n, out_valid && out_data.status == ST_FULL |-> out_data.element_count == 7'(DEPTH), "full status with room left")

  // An empty report shows an empty list and no value.
  `ASSERT_NEVER(a_empty_count, clk, rst_n, out_valid && out_data.status == ST_EMPTY && (out_data.element_count != 7'd0 || out_data.result_value != 32'd0), "empty status with elements or value")

endmodule

bind linked_deque_with_search ldq_chk #(.DEPTH(DEPTH)) u_ldq_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
